>>> sv/stack_alu_ops_defines.svh
// Assertion macros used by stack_alu_ops.sv.
`ifndef STACK_ALU_OPS_DEFINES_SVH
`define STACK_ALU_OPS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SAO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sao_pkg.sv
package sao_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 256;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_SWAP = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_MUL  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] top_value;
		logic [8:0]         stack_count;
	} rsp_t;

endpackage

>>> sv/stack_alu_ops.sv
// Stack machine ALU over a bounded stack of 32-bit signed words.
// Request channel (req_valid/req_stall/req) carries one operation per beat:
// push, swap, add, sub, div or mul. Response channel (rsp_valid/rsp_stall/rsp)
// returns exactly one beat per request: status, new top word, word count.
// One request is worked at a time; req_stall is high from acceptance until
// the response beat is loaded into the output register.
// The response beat is loaded in S_FIN: push, error cases and unused codes go
// there directly; swap, add, sub and mul pass through S_EXEC first; div goes
// through S_EXEC, S_DIV (the 32-step restoring divider that produces one
// quotient bit per cycle) and S_SIGN. A new request can be taken the cycle
// after the response is loaded, so requests never overlap.
// The top word lives in a register; words below it live in a synchronous RAM
// with one read and one write port, read into a register.
// Reset clears the word count and all control state; RAM contents are not
// cleared, and a RAM word is never used before being written.
// A stalled response holds in the output register; the next request may be
// accepted meanwhile, but its response waits until the held beat is taken.
`include "stack_alu_ops_defines.svh"

module stack_alu_ops #(
	parameter int unsigned STACK_DEPTH = sao_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sao_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sao_pkg::rsp_t rsp
);
	import sao_pkg::*;

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW    = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_DIV  = 5'b00100,
		S_SIGN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [2:0]        op_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       top_q;
	logic [31:0]       rd_data_q;
	logic [31:0]       mem [STACK_DEPTH];

	logic [31:0]       dvd_q;
	logic [31:0]       den_q;
	logic [31:0]       rem_q;
	logic              qneg_q;
	logic [4:0]        div_cnt_q;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              full;
	logic              push_ok;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [31:0]       mem_wdata;
	logic [AW-1:0]     sec_addr;
	logic [32:0]       rem_sh;
	logic [32:0]       rem_diff;
	logic              out_free;
	logic [31:0]       mag_n;
	logic [31:0]       mag_d;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign push_ok   = accept && (req.req_type == OP_PUSH) && !full;
	assign sec_addr  = AW'(count_q - CNT_W'(2));
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign mag_n = rd_data_q[31] ? (32'd0 - rd_data_q) : rd_data_q;
	assign mag_d = top_q[31] ? (32'd0 - top_q) : top_q;

	assign rem_sh   = {rem_q, dvd_q[31]};
	assign rem_diff = rem_sh - {1'b0, den_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sec_addr;
		mem_wdata = top_q;
		if (push_ok && (count_q != '0)) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(count_q - CNT_W'(1));
		end else if ((state_q == S_EXEC) && (op_q == OP_SWAP)) begin
			mem_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_data_q <= mem[sec_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			dvd_q  <= mag_n;
			den_q  <= mag_d;
			rem_q  <= '0;
			qneg_q <= rd_data_q[31] ^ top_q[31];
		end else if (state_q == S_DIV) begin
			if (!rem_diff[32]) begin
				rem_q <= rem_diff[31:0];
			end else begin
				rem_q <= rem_sh[31:0];
			end
			dvd_q <= {dvd_q[30:0], !rem_diff[32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_PUSH;
			status_q    <= ST_OK;
			count_q     <= '0;
			top_q       <= '0;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.req_type;
						case (req.req_type)
							OP_PUSH: begin
								state_q <= S_FIN;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									top_q    <= req.push_value;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
								if (count_q < CNT_W'(2)) begin
									status_q <= ST_SHORT;
									state_q  <= S_FIN;
								end else if ((req.req_type == OP_DIV) && (top_q == '0)) begin
									status_q <= ST_DIVZERO;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_EXEC;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_EXEC: begin
					case (op_q)
						OP_SWAP: begin
							top_q   <= rd_data_q;
							state_q <= S_FIN;
						end
						OP_ADD: begin
							top_q   <= rd_data_q + top_q;
							count_q <= count_q - CNT_W'(1);
							state_q <= S_FIN;
						end
						OP_SUB: begin
							top_q   <= rd_data_q - top_q;
							count_q <= count_q - CNT_W'(1);
							state_q <= S_FIN;
						end
						OP_DIV: begin
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
						default: begin
							top_q   <= rd_data_q * top_q;
							count_q <= count_q - CNT_W'(1);
							state_q <= S_FIN;
						end
					endcase
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					top_q   <= qneg_q ? (32'd0 - dvd_q) : dvd_q;
					count_q <= count_q - CNT_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						rsp_q.status      <= status_q;
						rsp_q.top_value   <= (count_q != '0) ? top_q : 32'd0;
						rsp_q.stack_count <= 9'(count_q);
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SAO_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "word count over depth")
	`SAO_ASSERT_NEXT(a_busy_after_accept, accept, state_q != S_IDLE, "idle after accept")
	`SAO_ASSERT_NEXT(a_push_grows, push_ok, count_q == $past(count_q) + CNT_W'(1), "push lost")

endmodule
